>>> hw/rtl/ddd_pkg.sv
`default_nettype none

package ddd_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DAY_NUM_W = 23;
  localparam int unsigned COUNT_W   = 22;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^15.
  localparam logic [14:0] RECIP_100   = 15'd20972;
  localparam int unsigned RECIP_SHIFT = 21;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Day number of one date and whether that date is valid.
  typedef struct packed {
    logic                 ok;
    logic [DAY_NUM_W-1:0] num;
  } dn_res_t;

  // Length of a month; zero for a month code outside January to December.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:           len = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:  len = 5'd30;
      MON_FEB:                             len = leap ? 5'd29 : 5'd28;
      default:                             len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the given month.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m,
                                             input logic leap);
    logic [8:0] n;
    logic [8:0] adj;
    adj = {8'd0, leap};
    unique case (m)
      MON_JAN: n = 9'd0;
      MON_FEB: n = 9'd31;
      MON_MAR: n = 9'd59  + adj;
      MON_APR: n = 9'd90  + adj;
      MON_MAY: n = 9'd120 + adj;
      MON_JUN: n = 9'd151 + adj;
      MON_JUL: n = 9'd181 + adj;
      MON_AUG: n = 9'd212 + adj;
      MON_SEP: n = 9'd243 + adj;
      MON_OCT: n = 9'd273 + adj;
      MON_NOV: n = 9'd304 + adj;
      MON_DEC: n = 9'd334 + adj;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ddd_day_number.sv
`default_nettype none

// Three-stage pipeline: date to days since 1 January of year 0, with a validity flag.
module ddd_day_number
  import ddd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [YEAR_W-1:0]  year,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [DAY_W-1:0]   day,
  output dn_res_t                 res
);

  // Stage 1: the three divisions by 100 as reciprocal multiplications.
  logic [14:0] y_ext;
  logic [14:0] ya;
  logic [14:0] yb;
  logic [29:0] prod_y;
  logic [29:0] prod_a;
  logic [29:0] prod_b;

  logic [YEAR_W-1:0]  y1_r;
  logic [MONTH_W-1:0] m1_r;
  logic [DAY_W-1:0]   d1_r;
  logic [7:0]         qy1_r;
  logic [7:0]         qa1_r;
  logic [7:0]         qb1_r;

  assign y_ext  = {1'b0, year};
  assign ya     = y_ext + 15'd99;
  assign yb     = (y_ext + 15'd399) >> 2;
  assign prod_y = y_ext * RECIP_100;
  assign prod_a = ya * RECIP_100;
  assign prod_b = yb * RECIP_100;

  always_ff @(posedge clk) begin
    y1_r  <= year;
    m1_r  <= month;
    d1_r  <= day;
    qy1_r <= prod_y[RECIP_SHIFT+7:RECIP_SHIFT];
    qa1_r <= prod_a[RECIP_SHIFT+7:RECIP_SHIFT];
    qb1_r <= prod_b[RECIP_SHIFT+7:RECIP_SHIFT];
  end

  // Stage 2: leap flag and the day number of 1 January.
  logic [14:0]          hund;
  logic                 div100;
  logic                 leap;
  logic [14:0]          quad;
  logic [DAY_NUM_W-1:0] base;

  logic [DAY_NUM_W-1:0] base2_r;
  logic                 leap2_r;
  logic [MONTH_W-1:0]   m2_r;
  logic [DAY_W-1:0]     d2_r;

  assign hund   = {7'd0, qy1_r} * 15'd100;
  assign div100 = ({1'b0, y1_r} == hund);
  assign leap   = ((y1_r[1:0] == 2'd0) && !div100) || (div100 && (qy1_r[1:0] == 2'd0));
  assign quad   = ({1'b0, y1_r} + 15'd3) >> 2;
  assign base   = {9'd0, y1_r} * 23'd365
                + {8'd0, quad}
                - {15'd0, qa1_r}
                + {15'd0, qb1_r};

  always_ff @(posedge clk) begin
    base2_r <= base;
    leap2_r <= leap;
    m2_r    <= m1_r;
    d2_r    <= d1_r;
  end

  // Stage 3: month offset, day of month and the validity check.
  logic [DAY_W-1:0] len;
  dn_res_t          res3_r;

  assign len = month_len(m2_r, leap2_r);

  always_ff @(posedge clk) begin
    res3_r.ok  <= (len != '0) && (d2_r != '0) && (d2_r <= len);
    res3_r.num <= base2_r + {14'd0, days_before(m2_r, leap2_r)}
                + {18'd0, d2_r} - 23'd1;
  end

  assign res = res3_r;

endmodule

`default_nettype wire

>>> hw/rtl/date_difference_in_days.sv
// Gregorian date difference. Each word on the in_ ports carries a start and an end
// date (day, month, year) and is taken at every clock edge where start is high;
// busy is always low, so a new word may follow in every cycle. The result is on
// out_day_count and out_date_error, marked by out_strobe, for one cycle once the
// word has passed all of its register stages. The receiver cannot stall the
// block, and none is needed: the four register stages (year divisions, leap and
// year base, month offset and validity, then the difference) move forward every
// cycle, so throughput is one word per cycle.
// A date is invalid when its month lies outside 1 to 12 or its day outside 1 to
// the length of that month; the result then has out_date_error set and a count
// of zero. When the start is not before the end the counted days are zero. The
// include_last_day bit, written through the cfg_ port, which is always ready,
// adds one day to every valid result; the count saturates at the top of its
// 22-bit range. Write the bit only while no word is in flight.

`default_nettype none

module date_difference_in_days
  import ddd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               start,
  output logic                    busy,
  input  wire logic [DAY_W-1:0]   in_start_day,
  input  wire logic [MONTH_W-1:0] in_start_month,
  input  wire logic [YEAR_W-1:0]  in_start_year,
  input  wire logic [DAY_W-1:0]   in_end_day,
  input  wire logic [MONTH_W-1:0] in_end_month,
  input  wire logic [YEAR_W-1:0]  in_end_year,

  output logic                    out_strobe,
  output logic [COUNT_W-1:0]      out_day_count,
  output logic                    out_date_error,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_include_last_day
);

  // The pipeline never holds, so a word is accepted whenever start is high.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register.
  logic inc_r;
  logic inc_nxt;

  assign inc_nxt = (cfg_valid && cfg_ready) ? cfg_include_last_day : inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= 1'b0;
    end else begin
      inc_r <= inc_nxt;
    end
  end

  // One valid bit for each of the three stages inside the day-number units.
  logic [2:0] vld_r;
  logic [2:0] vld_nxt;

  assign vld_nxt = {vld_r[1:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Both dates run through identical units side by side.
  dn_res_t start_dn;
  dn_res_t end_dn;

  ddd_day_number u_start_dn (
    .clk   (clk),
    .year  (in_start_year),
    .month (in_start_month),
    .day   (in_start_day),
    .res   (start_dn)
  );

  ddd_day_number u_end_dn (
    .clk   (clk),
    .year  (in_end_year),
    .month (in_end_month),
    .day   (in_end_day),
    .res   (end_dn)
  );

  // Final stage: difference, optional last day, saturation and error override.
  logic                 err;
  logic [DAY_NUM_W-1:0] diff;
  logic [DAY_NUM_W:0]   sum;
  logic [COUNT_W-1:0]   count;

  always_comb begin
    err  = !start_dn.ok || !end_dn.ok;
    diff = (end_dn.num > start_dn.num) ? (end_dn.num - start_dn.num) : '0;
    sum  = {1'b0, diff} + {{DAY_NUM_W{1'b0}}, inc_r};
    if (err) begin
      count = '0;
    end else if (sum > {2'b00, COUNT_MAX}) begin
      count = COUNT_MAX;
    end else begin
      count = sum[COUNT_W-1:0];
    end
  end

  logic               strobe_r;
  logic [COUNT_W-1:0] count_r;
  logic               err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count;
    err_r   <= err;
  end

  assign out_strobe     = strobe_r;
  assign out_day_count  = count_r;
  assign out_date_error = err_r;

  // Every accepted word yields its result strobe once it has passed the stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_strobe)
    else $error("result strobe missing four cycles after an accepted word");

  // An invalid date always reports a zero count.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_date_error) |-> (out_day_count == '0))
    else $error("invalid date reported with a nonzero count");

  // With the last day included, a valid result is never zero.
  a_inc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_date_error && inc_r) |-> (out_day_count != '0))
    else $error("zero count despite include_last_day");

  // No strobe without an earlier accepted word that it belongs to.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n, 4)) |-> $past(start, 4))
    else $error("result strobe without an accepted word");

endmodule

`default_nettype wire
